// ===== src/html_href_extractor_macros.svh =====
// -----------------------------------------------------------------------------
// html_href_extractor assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// -----------------------------------------------------------------------------
`ifndef HTML_HREF_EXTRACTOR_MACROS_SVH
`define HTML_HREF_EXTRACTOR_MACROS_SVH

// Same-cycle implication.
`define HHE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HHE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hhe_pkg.sv =====
// -----------------------------------------------------------------------------
// hhe_pkg
// Types and character constants for the HTML link target scanner.
// -----------------------------------------------------------------------------
package hhe_pkg;

  localparam int unsigned LenWidth       = 13;
  localparam logic [LenWidth-1:0] MaxUrlLenReset = 13'd2048;

  // Scanner phases
  typedef enum logic [3:0] {
    PH_SEEK_LT  = 4'd0,
    PH_AFTER_LT = 4'd1,
    PH_SEEK_H   = 4'd2,
    PH_MATCH_R  = 4'd3,
    PH_MATCH_E  = 4'd4,
    PH_MATCH_F  = 4'd5,
    PH_SEEK_EQ  = 4'd6,
    PH_SKIP_WS  = 4'd7,
    PH_URL      = 4'd8
  } phase_t;

  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_EQ    = 8'h3D;  // =
  localparam logic [7:0] CH_A     = 8'h61;  // a
  localparam logic [7:0] CH_H     = 8'h68;  // h
  localparam logic [7:0] CH_R     = 8'h72;  // r
  localparam logic [7:0] CH_E     = 8'h65;  // e
  localparam logic [7:0] CH_F     = 8'h66;  // f
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       doc_start;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]          url_byte;
    logic                url_end;
    logic [LenWidth-1:0] url_length;
  } url_item_t;

  // Whitespace and quotes skipped before a URL starts
  function automatic logic is_lead_skip(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
           (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  // Bytes that close a URL
  function automatic logic is_url_stop(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_DQUOTE) ||
           (c == CH_SQUOTE) || (c == CH_GT);
  endfunction

endpackage

// ===== src/html_href_extractor.sv =====
// -----------------------------------------------------------------------------
// html_href_extractor
// Streams link targets (href values of <a> tags) out of an HTML byte stream.
// -----------------------------------------------------------------------------
// A byte enters the input register, where the combinational phase/count update
// decides its fate; its result, if it produces one, then waits in the output
// register. Throughput is one byte per clock while link_stall does not hold a
// result back, set by that phase update, which folds the rescans of a broken
// match or a cut-off URL into the same cycle.
// Each URL byte comes out as a result with url_end low; a non-empty URL is
// closed by one result with url_end high and the byte count in url_length.
// Empty URLs give nothing. URLs longer than the length limit are cut at that
// many bytes, and the byte that hits the limit is scanned again for a new tag.
// doc_start on a byte restarts the scanner before that byte, dropping any
// half-read URL without an end result. The length limit (reset 2048) is
// written through the cfg channel, which is always ready; write it only while
// idle.
// -----------------------------------------------------------------------------
`include "html_href_extractor_macros.svh"

module html_href_extractor #(
  parameter logic [hhe_pkg::LenWidth-1:0] MaxUrlLenInit = hhe_pkg::MaxUrlLenReset
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte stream
  input  logic                          src_valid,
  output logic                          src_stall,
  input  hhe_pkg::byte_item_t           src_item,
  // link target stream
  output logic                          link_valid,
  input  logic                          link_stall,
  output hhe_pkg::url_item_t            link_item,
  // length limit write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hhe_pkg::LenWidth-1:0]  cfg_data
);

  // Config
  logic [hhe_pkg::LenWidth-1:0] len_limit;

  // Input register
  logic                s1_valid;
  hhe_pkg::byte_item_t s1;
  logic                s1_adv;

  // Scanner state
  hhe_pkg::phase_t              phase, phase_next;
  logic [hhe_pkg::LenWidth-1:0] taken_count, count_next;

  // Decode of the current byte
  hhe_pkg::phase_t              ph_cur;
  logic [hhe_pkg::LenWidth-1:0] cnt_cur;
  logic [hhe_pkg::LenWidth-1:0] url_cnt;
  logic                         url_go;     // byte handled by the URL step
  logic                         url_close;  // URL step ends the URL
  logic                         c_stop;
  logic                         rescan;

  // Result of the current byte
  logic               res_valid;
  hhe_pkg::url_item_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit <= MaxUrlLenInit;
    end else if (cfg_valid && cfg_ready) begin
      len_limit <= cfg_data;
    end
  end

  // Byte advances when it makes no result or the output register frees up
  assign s1_adv    = s1_valid && (!res_valid || !link_valid || !link_stall);
  assign src_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_valid && !src_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      s1 <= src_item;
    end
  end

  // doc_start restarts the scan before the byte is looked at
  always_comb begin
    ph_cur  = s1.doc_start ? hhe_pkg::PH_SEEK_LT : phase;
    cnt_cur = s1.doc_start ? '0 : taken_count;
    c_stop  = hhe_pkg::is_url_stop(s1.in_byte);
    url_go  = 1'b0;
    url_cnt = cnt_cur;
    case (ph_cur)
      hhe_pkg::PH_SKIP_WS: begin
        // First byte that is neither blank nor a quote opens the URL with an empty count
        if (!hhe_pkg::is_lead_skip(s1.in_byte)) begin
          url_go  = 1'b1;
          url_cnt = '0;
        end
      end
      hhe_pkg::PH_URL: begin
        url_go = 1'b1;
      end
      default: begin
        url_go = 1'b0;
      end
    endcase
    url_close = url_go && (c_stop || (url_cnt >= len_limit));
  end

  // Next state
  always_comb begin
    phase_next = ph_cur;
    count_next = cnt_cur;
    rescan     = 1'b0;
    case (ph_cur)
      hhe_pkg::PH_AFTER_LT: begin
        if (s1.in_byte == hhe_pkg::CH_A) phase_next = hhe_pkg::PH_SEEK_H;
        else rescan = 1'b1;
      end
      hhe_pkg::PH_SEEK_H: begin
        if (s1.in_byte == hhe_pkg::CH_H) phase_next = hhe_pkg::PH_MATCH_R;
      end
      hhe_pkg::PH_MATCH_R: begin
        if (s1.in_byte == hhe_pkg::CH_R) phase_next = hhe_pkg::PH_MATCH_E;
        else rescan = 1'b1;
      end
      hhe_pkg::PH_MATCH_E: begin
        if (s1.in_byte == hhe_pkg::CH_E) phase_next = hhe_pkg::PH_MATCH_F;
        else rescan = 1'b1;
      end
      hhe_pkg::PH_MATCH_F: begin
        if (s1.in_byte == hhe_pkg::CH_F) phase_next = hhe_pkg::PH_SEEK_EQ;
        else rescan = 1'b1;
      end
      hhe_pkg::PH_SEEK_EQ: begin
        if (s1.in_byte == hhe_pkg::CH_EQ) phase_next = hhe_pkg::PH_SKIP_WS;
      end
      hhe_pkg::PH_SKIP_WS, hhe_pkg::PH_URL: begin
        if (url_close) begin
          count_next = '0;
          rescan     = !c_stop;  // cut off: byte starts a new tag search
          phase_next = hhe_pkg::PH_SEEK_LT;
        end else if (url_go) begin
          count_next = url_cnt + 1'b1;
          phase_next = hhe_pkg::PH_URL;
        end
      end
      default: begin
        // tag search, also for unused codes
        rescan = 1'b1;
      end
    endcase
    if (rescan) begin
      phase_next = (s1.in_byte == hhe_pkg::CH_LT) ? hhe_pkg::PH_AFTER_LT
                                                  : hhe_pkg::PH_SEEK_LT;
    end
  end

  // Result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (url_close) begin
      res_valid      = (url_cnt != '0);
      res.url_end    = 1'b1;
      res.url_length = url_cnt;
    end else if (url_go) begin
      res_valid    = 1'b1;
      res.url_byte = s1.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hhe_pkg::PH_SEEK_LT;
      taken_count <= '0;
    end else if (s1_adv) begin
      phase       <= phase_next;
      taken_count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= 1'b0;
    end else if (s1_adv && res_valid) begin
      link_valid <= 1'b1;
    end else if (!link_stall) begin
      link_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      link_item <= res;
    end
  end

  // Checks
  `HHE_ASSERT_NOW(a_end_nonempty, link_valid && link_item.url_end, link_item.url_length != '0, "end result with zero length")
  `HHE_ASSERT_NOW(a_byte_not_stop, link_valid && !link_item.url_end, !hhe_pkg::is_url_stop(link_item.url_byte) && link_item.url_length == '0, "URL byte is a terminator")
  `HHE_ASSERT_NOW(a_count_only_in_url, phase != hhe_pkg::PH_URL, taken_count == '0, "count left outside URL phase")
  `HHE_ASSERT_NEXT(a_doc_restart, s1_adv && s1.doc_start, phase == hhe_pkg::PH_SEEK_LT || phase == hhe_pkg::PH_AFTER_LT, "new document did not restart the scan")

endmodule

// ===== dv/href_link_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// href_link_checker
// Watches the byte, link and length limit channels of the href scanner and
// predicts every link result from the accepted bytes. Each result is checked
// field by field against the oldest prediction.
// -----------------------------------------------------------------------------
module href_link_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         src_valid,
  input  logic                         src_stall,
  input  hhe_pkg::byte_item_t          src_item,
  input  logic                         link_valid,
  input  logic                         link_stall,
  input  hhe_pkg::url_item_t           link_item,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [hhe_pkg::LenWidth-1:0] cfg_data,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);

  hhe_pkg::phase_t              phase;
  logic [hhe_pkg::LenWidth-1:0] taken;
  logic [hhe_pkg::LenWidth-1:0] url_limit;
  hhe_pkg::url_item_t           expected_urls[$];
  hhe_pkg::url_item_t           oldest;

  function automatic bit closes_url(input logic [7:0] c);
    return c inside {hhe_pkg::CH_SP, hhe_pkg::CH_TAB, hhe_pkg::CH_DQUOTE,
                     hhe_pkg::CH_SQUOTE, hhe_pkg::CH_GT};
  endfunction

  // One input byte through the scanner; a rejected byte is scanned again
  function automatic void scan_byte(input hhe_pkg::byte_item_t it);
    logic [7:0]         c;
    bit                 rescan;
    int                 pass;
    hhe_pkg::url_item_t want;
    c = it.in_byte;
    if (it.doc_start) begin
      phase = hhe_pkg::PH_SEEK_LT;
      taken = '0;
    end
    rescan = 1'b1;
    for (pass = 0; pass < 4 && rescan; pass++) begin
      rescan = 1'b0;
      case (phase)
        hhe_pkg::PH_AFTER_LT: begin
          if (c == hhe_pkg::CH_A) phase = hhe_pkg::PH_SEEK_H;
          else begin
            phase = hhe_pkg::PH_SEEK_LT;
            rescan = 1'b1;
          end
        end
        hhe_pkg::PH_SEEK_H: if (c == hhe_pkg::CH_H) phase = hhe_pkg::PH_MATCH_R;
        hhe_pkg::PH_MATCH_R: begin
          if (c == hhe_pkg::CH_R) phase = hhe_pkg::PH_MATCH_E;
          else begin
            phase = hhe_pkg::PH_SEEK_LT;
            rescan = 1'b1;
          end
        end
        hhe_pkg::PH_MATCH_E: begin
          if (c == hhe_pkg::CH_E) phase = hhe_pkg::PH_MATCH_F;
          else begin
            phase = hhe_pkg::PH_SEEK_LT;
            rescan = 1'b1;
          end
        end
        hhe_pkg::PH_MATCH_F: begin
          if (c == hhe_pkg::CH_F) phase = hhe_pkg::PH_SEEK_EQ;
          else begin
            phase = hhe_pkg::PH_SEEK_LT;
            rescan = 1'b1;
          end
        end
        hhe_pkg::PH_SEEK_EQ: if (c == hhe_pkg::CH_EQ) phase = hhe_pkg::PH_SKIP_WS;
        hhe_pkg::PH_SKIP_WS: begin
          if (!(c inside {hhe_pkg::CH_SP, hhe_pkg::CH_TAB, hhe_pkg::CH_CR,
                          hhe_pkg::CH_LF, hhe_pkg::CH_DQUOTE, hhe_pkg::CH_SQUOTE})) begin
            phase = hhe_pkg::PH_URL;
            taken = '0;
            rescan = 1'b1;
          end
        end
        hhe_pkg::PH_URL: begin
          if (closes_url(c) || taken >= url_limit) begin
            // empty URLs give nothing; a cut-off byte goes back to tag search
            if (taken != '0) begin
              want.url_byte = 8'h00;
              want.url_end = 1'b1;
              want.url_length = taken;
              expected_urls.push_back(want);
            end
            rescan = !closes_url(c);
            taken = '0;
            phase = hhe_pkg::PH_SEEK_LT;
          end else begin
            want.url_byte = c;
            want.url_end = 1'b0;
            want.url_length = '0;
            expected_urls.push_back(want);
            taken = taken + 1'b1;
          end
        end
        default: phase = (c == hhe_pkg::CH_LT) ? hhe_pkg::PH_AFTER_LT : hhe_pkg::PH_SEEK_LT;
      endcase
    end
  endfunction

  task automatic report_miss(input string what, input hhe_pkg::url_item_t want,
                             input hhe_pkg::url_item_t got);
    if (fail_count < 10)
      $display("link mismatch (%s) @%0t: want byte %02h end %0b len %0d, got byte %02h end %0b len %0d",
               what, $realtime, want.url_byte, want.url_end, want.url_length,
               got.url_byte, got.url_end, got.url_length);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_urls.delete();
      phase = hhe_pkg::PH_SEEK_LT;
      taken = '0;
      url_limit = hhe_pkg::MaxUrlLenReset;
      fail_count = 0;
    end else begin
      if (link_valid && !link_stall) begin
        if (expected_urls.size() == 0) report_miss("no result expected", '0, link_item);
        else begin
          oldest = expected_urls.pop_front();
          if (link_item.url_byte !== oldest.url_byte ||
              link_item.url_end !== oldest.url_end ||
              link_item.url_length !== oldest.url_length)
            report_miss("field", oldest, link_item);
        end
      end
      if (cfg_valid && cfg_ready) url_limit = cfg_data;
      if (src_valid && !src_stall) scan_byte(src_item);
    end
    pending <= expected_urls.size();
  end

endmodule

// ===== dv/tb_html_href_extractor.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_html_href_extractor
// Drives HTML-like byte streams into the href scanner under several URL
// length limits, with random idling on both sides; href_link_checker
// predicts and checks the link results.
// -----------------------------------------------------------------------------
module tb_html_href_extractor;

  localparam int unsigned WatchdogLimit = 1000;  // cycles with no handshake at all
  localparam int unsigned ItemsPerPhase = 220;
  localparam int unsigned TailCycles = 8;        // two-stage pipe plus margin

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         src_valid = 1'b0;
  logic                         src_stall;
  hhe_pkg::byte_item_t          src_item = '0;
  logic                         link_valid;
  logic                         link_stall = 1'b0;
  hhe_pkg::url_item_t           link_item;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [hhe_pkg::LenWidth-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;  // no idling on either side while set

  // limits run after the directed part, which uses the reset value
  logic [hhe_pkg::LenWidth-1:0] url_limits[7] = '{13'd0, 13'd1, 13'd3, 13'd8191, 13'd4096,
                                                  13'd17, 13'd2048};
  logic [7:0] lead_skips[6] = '{hhe_pkg::CH_SP, hhe_pkg::CH_TAB, hhe_pkg::CH_CR,
                                hhe_pkg::CH_LF, hhe_pkg::CH_DQUOTE, hhe_pkg::CH_SQUOTE};
  logic [7:0] url_stops[5]  = '{hhe_pkg::CH_SP, hhe_pkg::CH_TAB, hhe_pkg::CH_DQUOTE,
                                hhe_pkg::CH_SQUOTE, hhe_pkg::CH_GT};
  logic [7:0] href_tail[3]  = '{hhe_pkg::CH_R, hhe_pkg::CH_E, hhe_pkg::CH_F};

  always #4 clk = ~clk;

  html_href_extractor dut (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .link_valid (link_valid),
    .link_stall (link_stall),
    .link_item  (link_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  href_link_checker u_link_check (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .link_valid (link_valid),
    .link_stall (link_stall),
    .link_item  (link_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver back-pressure: about a third of the cycles, none in steady mode
  always @(posedge clk) link_stall <= !steady && ($urandom_range(0, 99) < 36);

  // Watchdog: any handshake on any channel resets the count
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (link_valid && !link_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte item; random idle cycles ahead of it, then hold until taken
  task automatic send_byte(input logic [7:0] b, input logic ds);
    while (!steady && $urandom_range(0, 99) < 36) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item.in_byte <= b;
    src_item.doc_start <= ds;
    do @(posedge clk); while (src_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Sender holds off until every predicted result is out, then lets the
  // pipe empty of bytes that give no result
  task automatic drain;
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Random part: mostly complete <a href=...> tags with random content,
  // the rest broken tags and plain noise. Only tag bytes count.
  task automatic random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned k;
    logic [7:0]  b;
    logic [7:0]  text[$];
    bit          lead_ds;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      text.delete();
      if (kind < 70) begin
        text.push_back(hhe_pkg::CH_LT);
        text.push_back(hhe_pkg::CH_A);
        repeat ($urandom_range(0, 3)) begin
          do b = 8'($urandom_range(0, 255)); while (b == hhe_pkg::CH_H);
          text.push_back(b);
        end
        text.push_back(hhe_pkg::CH_H);
        foreach (href_tail[j]) text.push_back(href_tail[j]);
        repeat ($urandom_range(0, 2)) begin
          do b = 8'($urandom_range(0, 255)); while (b == hhe_pkg::CH_EQ);
          text.push_back(b);
        end
        text.push_back(hhe_pkg::CH_EQ);
        repeat ($urandom_range(0, 3)) text.push_back(lead_skips[$urandom_range(0, 5)]);
        repeat ($urandom_range(0, 24)) begin
          do b = 8'($urandom_range(0, 255));
          while (b inside {hhe_pkg::CH_SP, hhe_pkg::CH_TAB, hhe_pkg::CH_DQUOTE,
                           hhe_pkg::CH_SQUOTE, hhe_pkg::CH_GT});
          text.push_back(b);
        end
        // now and then the URL runs straight into the next tag
        if ($urandom_range(0, 9) != 0) text.push_back(url_stops[$urandom_range(0, 4)]);
      end else if (kind < 85) begin
        text.push_back(hhe_pkg::CH_LT);
        if ($urandom_range(0, 1) == 0) text.push_back(8'($urandom_range(0, 255)));
        else begin
          // "<ah" plus a partial "ref", then a random byte that may break it
          text.push_back(hhe_pkg::CH_A);
          text.push_back(hhe_pkg::CH_H);
          k = $urandom_range(0, 2);
          for (int j = 0; j < k; j++) text.push_back(href_tail[j]);
          text.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end
      // new documents now and then, sometimes in the middle of a tag or URL
      lead_ds = ($urandom_range(0, 99) < 3);
      foreach (text[i])
        send_byte(text[i], (i == 0 && lead_ds) || ($urandom_range(0, 199) == 0));
      if (kind < 85) sent += text.size();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset limit: new document on the first byte, a space and a quote
    // skipped, zero and all-ones URL bytes, '>' closes a 2-byte URL
    send_byte(hhe_pkg::CH_LT, 1'b1);
    send_text("ahref= \"");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(hhe_pkg::CH_GT, 1'b0);
    // "<<a": second '<' breaks the tag open and is rescanned; empty URL
    send_text("<<ahref=>");
    // half-read URL dropped by a new document, no end result
    send_text("<ahref=q");
    send_byte(8'h7A, 1'b1);
    drain();

    // One phase per limit; the block is idle before every write
    foreach (url_limits[p]) begin
      cfg_valid <= 1'b1;
      cfg_data <= url_limits[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      steady = (p == 3);
      random_phase(ItemsPerPhase);
      steady = 1'b0;
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
